// File: hdl/sawarq_pkg.sv
// ----------------------------------------------------------------------------
// sawarq_pkg
// Shared codes, limits and the result word type for the stop-and-wait sender.
// ----------------------------------------------------------------------------
package sawarq_pkg;

    localparam int OP_W     = 3;
    localparam int SIZE_W   = 13;
    localparam int NUM_W    = 16;
    localparam int TXFLAG_W = 5;
    localparam int STATUS_W = 3;

    // operation codes of an input word
    localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
    localparam logic [OP_W-1:0] OP_OPEN  = 3'd1;
    localparam logic [OP_W-1:0] OP_SEND  = 3'd2;
    localparam logic [OP_W-1:0] OP_RECV  = 3'd3;
    localparam logic [OP_W-1:0] OP_CLOSE = 3'd4;

    // received flag words
    localparam logic [NUM_W-1:0] RX_ACK     = 16'h0002;
    localparam logic [NUM_W-1:0] RX_SYN_ACK = 16'h0003;
    localparam logic [NUM_W-1:0] RX_FIN_ACK = 16'h0006;

    // transmitted flags
    localparam logic [TXFLAG_W-1:0] FL_NONE  = 5'h00;
    localparam logic [TXFLAG_W-1:0] FL_SYN   = 5'h01;
    localparam logic [TXFLAG_W-1:0] FL_ACK   = 5'h02;
    localparam logic [TXFLAG_W-1:0] FL_FIN   = 5'h04;
    localparam logic [TXFLAG_W-1:0] FL_OVER  = 5'h08;
    localparam logic [TXFLAG_W-1:0] FL_START = 5'h10;

    // status codes
    localparam logic [STATUS_W-1:0] ST_NONE      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SENT      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RETX      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ACKED     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CONNECTED = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CLOSED    = 3'd5;
    localparam logic [STATUS_W-1:0] ST_FAILED    = 3'd6;

    localparam logic [SIZE_W-1:0] MAX_PAYLOAD   = 13'd4096;
    localparam logic [NUM_W-1:0]  SEQ_CTRL      = 16'hFFFF;
    localparam logic [NUM_W-1:0]  TIMEOUT_RESET = 16'd200;

    typedef struct packed {
        logic                tx_send;
        logic [TXFLAG_W-1:0] tx_flag;
        logic [NUM_W-1:0]    tx_seq;
        logic [NUM_W-1:0]    tx_stream;
        logic [SIZE_W-1:0]   tx_size;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

// File: hdl/sawarq_core.sv
// ----------------------------------------------------------------------------
// sawarq_core
// Connection state, counters and retransmit timer; turns one event into at
// most one result word in the cycle it is accepted.
// ----------------------------------------------------------------------------
module sawarq_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [sawarq_pkg::NUM_W-1:0]        cfg_wr_data,
    input  logic                                accept,
    input  logic [sawarq_pkg::OP_W-1:0]         operation,
    input  logic                                seg_first,
    input  logic                                seg_last,
    input  logic [sawarq_pkg::SIZE_W-1:0]       seg_size,
    input  logic [sawarq_pkg::NUM_W-1:0]        rx_flag,
    input  logic [sawarq_pkg::NUM_W-1:0]        rx_seq,
    input  logic                                rx_cksum_ok,
    output logic                                res_valid,
    output sawarq_pkg::result_t                 res
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_OPEN_WAIT,
        PH_READY,
        PH_DATA_WAIT,
        PH_FIN_WAIT,
        PH_FINACK_WAIT
    } phase_t;

    phase_t                              phase_reg,   phase_next;
    logic [sawarq_pkg::NUM_W-1:0]        timeout_reg;
    logic [sawarq_pkg::NUM_W-1:0]        seq_reg,     seq_next;
    logic [sawarq_pkg::NUM_W-1:0]        stream_reg,  stream_next;
    logic [sawarq_pkg::NUM_W-1:0]        timer_reg,   timer_next;
    logic [sawarq_pkg::TXFLAG_W-1:0]     hflag_reg,   hflag_next;
    logic [sawarq_pkg::SIZE_W-1:0]       hsize_reg,   hsize_next;

    logic [sawarq_pkg::NUM_W-1:0]        limit;
    logic [sawarq_pkg::NUM_W-1:0]        timer_inc;
    logic [sawarq_pkg::SIZE_W-1:0]       size_sat;
    logic [sawarq_pkg::NUM_W-1:0]        seq_start;
    logic [sawarq_pkg::TXFLAG_W-1:0]     seg_flag;

    assign limit     = (timeout_reg == '0) ? sawarq_pkg::NUM_W'(1) : timeout_reg;
    assign timer_inc = (timer_reg == sawarq_pkg::SEQ_CTRL) ? timer_reg
                                                           : timer_reg + 1'b1;
    assign size_sat  = (seg_size > sawarq_pkg::MAX_PAYLOAD) ? sawarq_pkg::MAX_PAYLOAD
                                                           : seg_size;
    assign seq_start = seg_first ? '0 : seq_reg;
    assign seg_flag  = (seg_first ? sawarq_pkg::FL_START : sawarq_pkg::FL_NONE)
                     | (seg_last  ? sawarq_pkg::FL_OVER  : sawarq_pkg::FL_NONE);

    always_comb
    begin
        phase_next  = phase_reg;
        seq_next    = seq_reg;
        stream_next = stream_reg;
        timer_next  = timer_reg;
        hflag_next  = hflag_reg;
        hsize_next  = hsize_reg;
        res_valid   = 1'b0;
        res         = '0;

        if (accept)
        begin
            unique case (operation)
                sawarq_pkg::OP_TICK:
                begin
                    if (phase_reg == PH_OPEN_WAIT || phase_reg == PH_DATA_WAIT ||
                        phase_reg == PH_FIN_WAIT)
                    begin
                        if (timer_inc < limit)
                        begin
                            timer_next = timer_inc;
                        end
                        else
                        begin
                            // resend the held header
                            timer_next    = '0;
                            res_valid     = 1'b1;
                            res.tx_send   = 1'b1;
                            res.tx_flag   = hflag_reg;
                            res.status    = sawarq_pkg::ST_RETX;
                            if (phase_reg == PH_DATA_WAIT)
                            begin
                                res.tx_seq    = seq_reg;
                                res.tx_stream = stream_reg;
                                res.tx_size   = hsize_reg;
                            end
                            else
                            begin
                                res.tx_seq    = sawarq_pkg::SEQ_CTRL;
                            end
                        end
                    end
                end
                sawarq_pkg::OP_OPEN:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        phase_next  = PH_OPEN_WAIT;
                        hflag_next  = sawarq_pkg::FL_SYN;
                        hsize_next  = '0;
                        timer_next  = '0;
                        res_valid   = 1'b1;
                        res.tx_send = 1'b1;
                        res.tx_flag = sawarq_pkg::FL_SYN;
                        res.tx_seq  = sawarq_pkg::SEQ_CTRL;
                        res.status  = sawarq_pkg::ST_SENT;
                    end
                end
                sawarq_pkg::OP_SEND:
                begin
                    if (phase_reg == PH_READY)
                    begin
                        phase_next    = PH_DATA_WAIT;
                        seq_next      = seq_start;
                        hflag_next    = seg_flag;
                        hsize_next    = size_sat;
                        timer_next    = '0;
                        res_valid     = 1'b1;
                        res.tx_send   = 1'b1;
                        res.tx_flag   = seg_flag;
                        res.tx_seq    = seq_start;
                        res.tx_stream = stream_reg;
                        res.tx_size   = size_sat;
                        res.status    = sawarq_pkg::ST_SENT;
                    end
                end
                sawarq_pkg::OP_RECV:
                begin
                    unique case (phase_reg)
                        PH_OPEN_WAIT:
                        begin
                            res_valid = 1'b1;
                            if (rx_flag == sawarq_pkg::RX_SYN_ACK && rx_cksum_ok &&
                                rx_seq == sawarq_pkg::SEQ_CTRL)
                            begin
                                phase_next  = PH_READY;
                                res.tx_send = 1'b1;
                                res.tx_flag = sawarq_pkg::FL_ACK;
                                res.status  = sawarq_pkg::ST_CONNECTED;
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                                res.status = sawarq_pkg::ST_FAILED;
                            end
                        end
                        PH_DATA_WAIT:
                        begin
                            // drop anything but a clean ACK of the held seq
                            if (rx_flag == sawarq_pkg::RX_ACK && rx_cksum_ok &&
                                rx_seq == seq_reg)
                            begin
                                phase_next = PH_READY;
                                seq_next   = seq_reg + 1'b1;
                                if ((hflag_reg & sawarq_pkg::FL_OVER) != '0)
                                begin
                                    stream_next = stream_reg + 1'b1;
                                end
                                res_valid  = 1'b1;
                                res.status = sawarq_pkg::ST_ACKED;
                            end
                        end
                        PH_FIN_WAIT:
                        begin
                            if (rx_flag == sawarq_pkg::RX_ACK && rx_cksum_ok &&
                                rx_seq == '0)
                            begin
                                phase_next = PH_FINACK_WAIT;
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                                res_valid  = 1'b1;
                                res.status = sawarq_pkg::ST_FAILED;
                            end
                        end
                        PH_FINACK_WAIT:
                        begin
                            phase_next = PH_IDLE;
                            res_valid  = 1'b1;
                            if (rx_flag == sawarq_pkg::RX_FIN_ACK && rx_cksum_ok &&
                                rx_seq == sawarq_pkg::SEQ_CTRL)
                            begin
                                res.tx_send = 1'b1;
                                res.tx_flag = sawarq_pkg::FL_ACK;
                                res.status  = sawarq_pkg::ST_CLOSED;
                            end
                            else
                            begin
                                res.status = sawarq_pkg::ST_FAILED;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                sawarq_pkg::OP_CLOSE:
                begin
                    if (phase_reg == PH_READY)
                    begin
                        phase_next  = PH_FIN_WAIT;
                        hflag_next  = sawarq_pkg::FL_FIN;
                        hsize_next  = '0;
                        timer_next  = '0;
                        res_valid   = 1'b1;
                        res.tx_send = 1'b1;
                        res.tx_flag = sawarq_pkg::FL_FIN;
                        res.tx_seq  = sawarq_pkg::SEQ_CTRL;
                        res.status  = sawarq_pkg::ST_SENT;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            timeout_reg <= sawarq_pkg::TIMEOUT_RESET;
            seq_reg     <= '0;
            stream_reg  <= '0;
            timer_reg   <= '0;
            hflag_reg   <= '0;
            hsize_reg   <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            seq_reg     <= seq_next;
            stream_reg  <= stream_next;
            timer_reg   <= timer_next;
            hflag_reg   <= hflag_next;
            hsize_reg   <= hsize_next;
            if (cfg_wr_en)
            begin
                timeout_reg <= cfg_wr_data;
            end
        end
    end

endmodule

// File: hdl/sawarq_obuf.sv
// ----------------------------------------------------------------------------
// sawarq_obuf
// Two-entry result buffer; keeps the event side running while a result
// word waits for the receiver.
// ----------------------------------------------------------------------------
module sawarq_obuf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sawarq_pkg::result_t push_data,
    input  logic                out_stall,
    output logic                out_valid,
    output logic                full,
    output sawarq_pkg::result_t out_data
);

    sawarq_pkg::result_t buf_reg [2];
    logic                head_reg,  head_next;
    logic [1:0]          count_reg, count_next;
    logic                pop;
    logic                wr_idx;
    logic [1:0]          wr_sum;

    assign out_valid = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign pop       = out_valid && !out_stall;
    assign out_data  = buf_reg[head_reg];
    assign wr_sum    = {1'b0, head_reg} + count_reg;
    assign wr_idx    = wr_sum[0];

    always_comb
    begin
        head_next  = pop ? ~head_reg : head_reg;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // payload storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_idx] <= push_data;
        end
    end

endmodule

// File: hdl/stop_and_wait_arq_sender.sv
// ----------------------------------------------------------------------------
// stop_and_wait_arq_sender
// Sender side of a stop-and-wait link with three-way open and four-way close.
// ----------------------------------------------------------------------------
// Takes one event word per clock while in_stall is low (tick, open, send
// segment, received packet, close) and answers each with zero or one result
// word carrying a packet header and a status code. An event is handled in
// the cycle it is accepted; its result word goes in that same cycle into a
// two-entry output buffer, and in_stall rises only when both entries hold
// words the receiver has not yet taken.
// timeout_ticks may be written only while the block is idle.
module stop_and_wait_arq_sender (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [sawarq_pkg::NUM_W-1:0]        cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [sawarq_pkg::OP_W-1:0]         operation,
    input  logic                                seg_first,
    input  logic                                seg_last,
    input  logic [sawarq_pkg::SIZE_W-1:0]       seg_size,
    input  logic [sawarq_pkg::NUM_W-1:0]        rx_flag,
    input  logic [sawarq_pkg::NUM_W-1:0]        rx_seq,
    input  logic                                rx_cksum_ok,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                tx_send,
    output logic [sawarq_pkg::TXFLAG_W-1:0]     tx_flag,
    output logic [sawarq_pkg::NUM_W-1:0]        tx_seq,
    output logic [sawarq_pkg::NUM_W-1:0]        tx_stream,
    output logic [sawarq_pkg::SIZE_W-1:0]       tx_size,
    output logic [sawarq_pkg::STATUS_W-1:0]     status
);

    logic                accept;
    logic                full;
    logic                res_valid;
    sawarq_pkg::result_t res;
    sawarq_pkg::result_t out_data;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    sawarq_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .operation   (operation),
        .seg_first   (seg_first),
        .seg_last    (seg_last),
        .seg_size    (seg_size),
        .rx_flag     (rx_flag),
        .rx_seq      (rx_seq),
        .rx_cksum_ok (rx_cksum_ok),
        .res_valid   (res_valid),
        .res         (res)
    );

    sawarq_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .full      (full),
        .out_data  (out_data)
    );

    assign tx_send   = out_data.tx_send;
    assign tx_flag   = out_data.tx_flag;
    assign tx_seq    = out_data.tx_seq;
    assign tx_stream = out_data.tx_stream;
    assign tx_size   = out_data.tx_size;
    assign status    = out_data.status;

endmodule

// File: hdl/sawarq_checker.sv
// ----------------------------------------------------------------------------
// sawarq_checker
// Port-level checks for the stop-and-wait sender, bound to the top level.
// ----------------------------------------------------------------------------
module sawarq_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_stall,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic                                tx_send,
    input  logic [sawarq_pkg::TXFLAG_W-1:0]     tx_flag,
    input  logic [sawarq_pkg::NUM_W-1:0]        tx_seq,
    input  logic [sawarq_pkg::NUM_W-1:0]        tx_stream,
    input  logic [sawarq_pkg::SIZE_W-1:0]       tx_size,
    input  logic [sawarq_pkg::STATUS_W-1:0]     status
);

    // stall only while words are pending on the output
    a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("in_stall without pending output word");

    // every result word carries a status
    a_status_present: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != sawarq_pkg::ST_NONE)
        else $error("result word with no status");

    // header fields are clear when nothing is sent
    a_idle_header: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !tx_send) |->
            (tx_flag == '0 && tx_seq == '0 && tx_stream == '0 && tx_size == '0))
        else $error("header fields set without tx_send");

    // hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(tx_send) && $stable(tx_flag) && $stable(tx_seq) &&
             $stable(tx_stream) && $stable(tx_size) && $stable(status)))
        else $error("stalled result word changed");

endmodule

bind stop_and_wait_arq_sender sawarq_checker u_sawarq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .tx_send   (tx_send),
    .tx_flag   (tx_flag),
    .tx_seq    (tx_seq),
    .tx_stream (tx_stream),
    .tx_size   (tx_size),
    .status    (status)
);

// File: tb/tb_stop_and_wait_arq_sender.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stop_and_wait_arq_sender
// Self-checking bench for the stop-and-wait ARQ sender.
// ----------------------------------------------------------------------------
// Feeds event words through the valid/stall input port with random gaps and
// keeps its own copy of the connection state, the counters and the retransmit
// timer. Each result word is checked field by field against the oldest
// predicted reply. Covers the open and close handshakes, their failures, data
// transfer with size saturation and stream advance, retransmits at several
// timeout settings, output back-pressure and long random sessions.
// ----------------------------------------------------------------------------
module tb_stop_and_wait_arq_sender;

    typedef logic [sawarq_pkg::OP_W-1:0]   op_code_t;
    typedef logic [sawarq_pkg::NUM_W-1:0]  num_t;
    typedef logic [sawarq_pkg::SIZE_W-1:0] len_t;

    localparam op_code_t OP_UNUSED     = 3'd7;
    localparam int       DRAIN_LIMIT   = 5000;
    localparam int       SETTLE_CYCLES = 4;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_OPEN_WAIT,
        PH_READY,
        PH_DATA_WAIT,
        PH_FIN_WAIT,
        PH_FINACK_WAIT
    } link_phase_t;

    typedef struct packed {
        logic [sawarq_pkg::OP_W-1:0]   op;
        logic                          seg_first;
        logic                          seg_last;
        logic [sawarq_pkg::SIZE_W-1:0] seg_size;
        logic [sawarq_pkg::NUM_W-1:0]  rx_flag;
        logic [sawarq_pkg::NUM_W-1:0]  rx_seq;
        logic                          rx_cksum_ok;
    } arq_event_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_wr_en = 1'b0;
    logic [sawarq_pkg::NUM_W-1:0]      cfg_wr_data = '0;
    logic                              in_valid = 1'b0;
    logic                              in_stall;
    logic [sawarq_pkg::OP_W-1:0]       operation = sawarq_pkg::OP_TICK;
    logic                              seg_first = 1'b0;
    logic                              seg_last = 1'b0;
    logic [sawarq_pkg::SIZE_W-1:0]     seg_size = '0;
    logic [sawarq_pkg::NUM_W-1:0]      rx_flag = '0;
    logic [sawarq_pkg::NUM_W-1:0]      rx_seq = '0;
    logic                              rx_cksum_ok = 1'b0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic                              tx_send;
    logic [sawarq_pkg::TXFLAG_W-1:0]   tx_flag;
    logic [sawarq_pkg::NUM_W-1:0]      tx_seq;
    logic [sawarq_pkg::NUM_W-1:0]      tx_stream;
    logic [sawarq_pkg::SIZE_W-1:0]     tx_size;
    logic [sawarq_pkg::STATUS_W-1:0]   status;

    // predicted sender state
    link_phase_t                       link_phase;
    logic [sawarq_pkg::NUM_W-1:0]      seq_count;
    logic [sawarq_pkg::NUM_W-1:0]      stream_count;
    logic [sawarq_pkg::NUM_W-1:0]      wait_timer;
    logic [sawarq_pkg::NUM_W-1:0]      timeout_ticks;
    logic [sawarq_pkg::TXFLAG_W-1:0]   held_flag;
    logic [sawarq_pkg::SIZE_W-1:0]     held_size;

    sawarq_pkg::result_t expected_replies[$];
    int      failures = 0;
    int      events_posted = 0;
    bit      tx_idle_on = 1'b1;
    bit      rx_idle_on = 1'b1;
    int      rx_hold_cycles = 0;
    int      rx_gap_left = 0;

    stop_and_wait_arq_sender dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .seg_first   (seg_first),
        .seg_last    (seg_last),
        .seg_size    (seg_size),
        .rx_flag     (rx_flag),
        .rx_seq      (rx_seq),
        .rx_cksum_ok (rx_cksum_ok),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .tx_send     (tx_send),
        .tx_flag     (tx_flag),
        .tx_seq      (tx_seq),
        .tx_stream   (tx_stream),
        .tx_size     (tx_size),
        .status      (status)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic sawarq_pkg::result_t make_reply(
        input logic send,
        input logic [sawarq_pkg::TXFLAG_W-1:0] flag,
        input logic [sawarq_pkg::NUM_W-1:0] seq,
        input logic [sawarq_pkg::NUM_W-1:0] stream,
        input logic [sawarq_pkg::SIZE_W-1:0] size,
        input logic [sawarq_pkg::STATUS_W-1:0] st);
        sawarq_pkg::result_t r;
        r.tx_send   = send;
        r.tx_flag   = flag;
        r.tx_seq    = seq;
        r.tx_stream = stream;
        r.tx_size   = size;
        r.status    = st;
        return r;
    endfunction

    // Control packets go out with the control sequence number and no payload.
    function automatic sawarq_pkg::result_t held_header(
        input logic [sawarq_pkg::STATUS_W-1:0] st);
        if (link_phase == PH_DATA_WAIT)
        begin
            return make_reply(1'b1, held_flag, seq_count, stream_count, held_size, st);
        end
        return make_reply(1'b1, held_flag, sawarq_pkg::SEQ_CTRL, '0, '0, st);
    endfunction

    function automatic bit predict_reply(input arq_event_t ev,
                                         output sawarq_pkg::result_t r);
        logic [sawarq_pkg::NUM_W-1:0] limit;
        r = '0;
        case (ev.op)
            sawarq_pkg::OP_TICK:
            begin
                if (link_phase != PH_OPEN_WAIT && link_phase != PH_DATA_WAIT &&
                    link_phase != PH_FIN_WAIT)
                begin
                    return 1'b0;
                end
                limit = (timeout_ticks == '0) ? 16'd1 : timeout_ticks;
                if (wait_timer != '1)
                begin
                    wait_timer = wait_timer + 1'b1;
                end
                if (wait_timer < limit)
                begin
                    return 1'b0;
                end
                wait_timer = '0;
                r = held_header(sawarq_pkg::ST_RETX);
                return 1'b1;
            end
            sawarq_pkg::OP_OPEN:
            begin
                if (link_phase != PH_IDLE)
                begin
                    return 1'b0;
                end
                link_phase = PH_OPEN_WAIT;
                held_flag  = sawarq_pkg::FL_SYN;
                held_size  = '0;
                wait_timer = '0;
                r = held_header(sawarq_pkg::ST_SENT);
                return 1'b1;
            end
            sawarq_pkg::OP_SEND:
            begin
                if (link_phase != PH_READY)
                begin
                    return 1'b0;
                end
                if (ev.seg_first)
                begin
                    seq_count = '0;
                end
                held_flag = (ev.seg_first ? sawarq_pkg::FL_START : sawarq_pkg::FL_NONE) |
                            (ev.seg_last ? sawarq_pkg::FL_OVER : sawarq_pkg::FL_NONE);
                held_size  = (ev.seg_size > sawarq_pkg::MAX_PAYLOAD) ?
                             sawarq_pkg::MAX_PAYLOAD : ev.seg_size;
                link_phase = PH_DATA_WAIT;
                wait_timer = '0;
                r = held_header(sawarq_pkg::ST_SENT);
                return 1'b1;
            end
            sawarq_pkg::OP_RECV:
            begin
                case (link_phase)
                    PH_OPEN_WAIT:
                    begin
                        if (ev.rx_flag == sawarq_pkg::RX_SYN_ACK && ev.rx_cksum_ok &&
                            ev.rx_seq == sawarq_pkg::SEQ_CTRL)
                        begin
                            link_phase = PH_READY;
                            r = make_reply(1'b1, sawarq_pkg::FL_ACK, '0, '0, '0,
                                           sawarq_pkg::ST_CONNECTED);
                        end
                        else
                        begin
                            link_phase = PH_IDLE;
                            r.status = sawarq_pkg::ST_FAILED;
                        end
                        return 1'b1;
                    end
                    PH_DATA_WAIT:
                    begin
                        // drop anything but a clean ACK for the held sequence number
                        if (!(ev.rx_flag == sawarq_pkg::RX_ACK && ev.rx_cksum_ok &&
                              ev.rx_seq == seq_count))
                        begin
                            return 1'b0;
                        end
                        seq_count = seq_count + 1'b1;
                        if ((held_flag & sawarq_pkg::FL_OVER) != sawarq_pkg::FL_NONE)
                        begin
                            stream_count = stream_count + 1'b1;
                        end
                        link_phase = PH_READY;
                        r.status = sawarq_pkg::ST_ACKED;
                        return 1'b1;
                    end
                    PH_FIN_WAIT:
                    begin
                        if (ev.rx_flag == sawarq_pkg::RX_ACK && ev.rx_cksum_ok &&
                            ev.rx_seq == '0)
                        begin
                            link_phase = PH_FINACK_WAIT;
                            return 1'b0;
                        end
                        link_phase = PH_IDLE;
                        r.status = sawarq_pkg::ST_FAILED;
                        return 1'b1;
                    end
                    PH_FINACK_WAIT:
                    begin
                        link_phase = PH_IDLE;
                        if (ev.rx_flag == sawarq_pkg::RX_FIN_ACK && ev.rx_cksum_ok &&
                            ev.rx_seq == sawarq_pkg::SEQ_CTRL)
                        begin
                            r = make_reply(1'b1, sawarq_pkg::FL_ACK, '0, '0, '0,
                                           sawarq_pkg::ST_CLOSED);
                        end
                        else
                        begin
                            r.status = sawarq_pkg::ST_FAILED;
                        end
                        return 1'b1;
                    end
                    default:
                    begin
                        return 1'b0;
                    end
                endcase
            end
            sawarq_pkg::OP_CLOSE:
            begin
                if (link_phase != PH_READY)
                begin
                    return 1'b0;
                end
                link_phase = PH_FIN_WAIT;
                held_flag  = sawarq_pkg::FL_FIN;
                held_size  = '0;
                wait_timer = '0;
                r = held_header(sawarq_pkg::ST_SENT);
                return 1'b1;
            end
            default:
            begin
                return 1'b0;
            end
        endcase
        return 1'b0;
    endfunction

    function automatic arq_event_t random_event();
        logic [63:0] noise;
        arq_event_t  ev;
        noise = {$urandom, $urandom};
        ev    = noise[$bits(arq_event_t)-1:0];
        return ev;
    endfunction

    // Start from the right answer and spoil exactly one part of it.
    function automatic arq_event_t broken_reply(input logic [sawarq_pkg::NUM_W-1:0] flag,
                                                input logic [sawarq_pkg::NUM_W-1:0] seq);
        arq_event_t ev;
        ev             = random_event();
        ev.op          = sawarq_pkg::OP_RECV;
        ev.rx_flag     = flag;
        ev.rx_seq      = seq;
        ev.rx_cksum_ok = 1'b1;
        case ($urandom_range(0, 3))
            0: ev.rx_cksum_ok = 1'b0;
            1: ev.rx_seq = seq ^ (16'd1 << $urandom_range(0, 15));
            2: ev.rx_flag = flag ^ (16'd1 << $urandom_range(0, 15));
            default: ev.rx_seq = num_t'($urandom);
        endcase
        return ev;
    endfunction

    // Offer one word, hold it until accepted, then record the predicted reply.
    task automatic post(input arq_event_t ev);
        int                  gap;
        sawarq_pkg::result_t r;
        gap = tx_idle_on ? $urandom_range(0, 12) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        operation   <= ev.op;
        seg_first   <= ev.seg_first;
        seg_last    <= ev.seg_last;
        seg_size    <= ev.seg_size;
        rx_flag     <= ev.rx_flag;
        rx_seq      <= ev.rx_seq;
        rx_cksum_ok <= ev.rx_cksum_ok;
        in_valid    <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        if (predict_reply(ev, r))
        begin
            expected_replies.push_back(r);
        end
        events_posted++;
        @(negedge clk);
    endtask

    task automatic post_ctl(input logic [sawarq_pkg::OP_W-1:0] op);
        arq_event_t ev;
        ev    = random_event();
        ev.op = op;
        post(ev);
    endtask

    task automatic post_seg(input logic first, input logic last,
                            input logic [sawarq_pkg::SIZE_W-1:0] size);
        arq_event_t ev;
        ev           = random_event();
        ev.op        = sawarq_pkg::OP_SEND;
        ev.seg_first = first;
        ev.seg_last  = last;
        ev.seg_size  = size;
        post(ev);
    endtask

    task automatic post_rx(input logic [sawarq_pkg::NUM_W-1:0] flag,
                           input logic [sawarq_pkg::NUM_W-1:0] seq,
                           input logic ok);
        arq_event_t ev;
        ev             = random_event();
        ev.op          = sawarq_pkg::OP_RECV;
        ev.rx_flag     = flag;
        ev.rx_seq      = seq;
        ev.rx_cksum_ok = ok;
        post(ev);
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (expected_replies.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        if (expected_replies.size() != 0)
        begin
            $error("%0d expected replies never arrived", expected_replies.size());
            failures++;
            expected_replies.delete();
        end
        // let a word that causes no reply clear the block
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Bring the link back to idle, then write the register.
    task automatic set_timeout(input logic [sawarq_pkg::NUM_W-1:0] value);
        drain();
        while (link_phase != PH_IDLE)
        begin
            case (link_phase)
                PH_READY:     post_ctl(sawarq_pkg::OP_CLOSE);
                PH_DATA_WAIT: post_rx(sawarq_pkg::RX_ACK, seq_count, 1'b1);
                default:      post_rx(num_t'($urandom), num_t'($urandom), 1'b0);
            endcase
        end
        drain();
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        timeout_ticks = value;
    endtask

    task automatic test_directed_session();
        post_ctl(sawarq_pkg::OP_TICK);
        post_rx(sawarq_pkg::RX_ACK, '0, 1'b1);
        post_seg(1'b1, 1'b1, '1);
        post_ctl(sawarq_pkg::OP_CLOSE);
        post_ctl(OP_UNUSED);
        post_ctl(sawarq_pkg::OP_OPEN);
        post_ctl(sawarq_pkg::OP_OPEN);
        post_rx(sawarq_pkg::RX_SYN_ACK, sawarq_pkg::SEQ_CTRL, 1'b0);
        post_ctl(sawarq_pkg::OP_OPEN);
        post_rx(sawarq_pkg::RX_SYN_ACK, sawarq_pkg::SEQ_CTRL, 1'b1);
        post_ctl(sawarq_pkg::OP_TICK);
        post_seg(1'b1, 1'b0, '0);
        post_ctl(sawarq_pkg::OP_TICK);
        post_rx(sawarq_pkg::RX_ACK, 16'd1, 1'b1);
        post_rx(sawarq_pkg::RX_ACK, '0, 1'b0);
        post_rx(sawarq_pkg::RX_ACK, '0, 1'b1);
        post_seg(1'b1, 1'b1, '1);
        post_rx(sawarq_pkg::RX_ACK, '0, 1'b1);
        post_seg(1'b0, 1'b1, sawarq_pkg::MAX_PAYLOAD);
        post_rx(sawarq_pkg::RX_ACK, seq_count, 1'b1);
        post_seg(1'b0, 1'b0, sawarq_pkg::MAX_PAYLOAD + 1'b1);
        post_rx(sawarq_pkg::RX_ACK, seq_count, 1'b1);
        post_ctl(sawarq_pkg::OP_CLOSE);
        post_rx(sawarq_pkg::RX_ACK, '0, 1'b1);
        post_rx(sawarq_pkg::RX_FIN_ACK, sawarq_pkg::SEQ_CTRL, 1'b1);
        drain();
    endtask

    task automatic test_handshake_failures();
        post_ctl(sawarq_pkg::OP_OPEN);
        post_rx(sawarq_pkg::RX_FIN_ACK, sawarq_pkg::SEQ_CTRL, 1'b1);
        post_ctl(sawarq_pkg::OP_OPEN);
        post_rx(sawarq_pkg::RX_SYN_ACK, '0, 1'b1);
        post_ctl(sawarq_pkg::OP_OPEN);
        post_rx(sawarq_pkg::RX_SYN_ACK, sawarq_pkg::SEQ_CTRL, 1'b1);
        post_ctl(sawarq_pkg::OP_CLOSE);
        post_rx(sawarq_pkg::RX_ACK, 16'd1, 1'b1);
        post_ctl(sawarq_pkg::OP_OPEN);
        post_rx(sawarq_pkg::RX_SYN_ACK, sawarq_pkg::SEQ_CTRL, 1'b1);
        post_ctl(sawarq_pkg::OP_CLOSE);
        post_rx(sawarq_pkg::RX_ACK, '0, 1'b1);
        post_rx(sawarq_pkg::RX_FIN_ACK, sawarq_pkg::SEQ_CTRL, 1'b0);
        drain();
    endtask

    task automatic test_retransmit();
        set_timeout(16'd3);
        post_ctl(sawarq_pkg::OP_OPEN);
        repeat (7) post_ctl(sawarq_pkg::OP_TICK);
        post_rx(sawarq_pkg::RX_SYN_ACK, sawarq_pkg::SEQ_CTRL, 1'b1);
        post_seg(1'b1, 1'b0, len_t'($urandom_range(0, 4096)));
        repeat (4) post_ctl(sawarq_pkg::OP_TICK);
        post_rx(sawarq_pkg::RX_ACK, seq_count, 1'b1);
        post_seg(1'b0, 1'b1, len_t'($urandom));
        repeat (6) post_ctl(sawarq_pkg::OP_TICK);
        post_rx(sawarq_pkg::RX_ACK, seq_count, 1'b1);
        post_ctl(sawarq_pkg::OP_CLOSE);
        repeat (3) post_ctl(sawarq_pkg::OP_TICK);
        post_rx(sawarq_pkg::RX_ACK, '0, 1'b1);
        // no timer while waiting for FIN_ACK
        repeat (5) post_ctl(sawarq_pkg::OP_TICK);
        post_rx(sawarq_pkg::RX_FIN_ACK, sawarq_pkg::SEQ_CTRL, 1'b1);
        drain();
    endtask

    task automatic test_timeout_extremes();
        logic [sawarq_pkg::NUM_W-1:0] settings[4] = '{16'd0, 16'd1, 16'd2, 16'hFFFF};
        int                           ticks;
        // reset value first, before any write
        post_ctl(sawarq_pkg::OP_OPEN);
        repeat (int'(sawarq_pkg::TIMEOUT_RESET) + 1) post_ctl(sawarq_pkg::OP_TICK);
        foreach (settings[i])
        begin
            set_timeout(settings[i]);
            if (settings[i] == '1)
            begin
                // far below the limit: no resend
                ticks = 24;
            end
            else
            begin
                ticks = 3 * ((settings[i] == '0) ? 1 : int'(settings[i]));
            end
            post_ctl(sawarq_pkg::OP_OPEN);
            repeat (ticks) post_ctl(sawarq_pkg::OP_TICK);
        end
        drain();
    endtask

    task automatic test_backpressure();
        set_timeout(16'd1);
        post_ctl(sawarq_pkg::OP_OPEN);
        tx_idle_on = 1'b0;
        rx_hold_cycles = 150;
        // every tick retransmits, so the output buffer fills and the input stalls
        repeat (40) post_ctl(sawarq_pkg::OP_TICK);
        tx_idle_on = 1'b1;
        drain();
    endtask

    task automatic test_random_sessions();
        int         goal;
        int         roll;
        arq_event_t ev;
        goal = events_posted + 900;
        while (events_posted < goal)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                roll = $urandom_range(0, 9);
                if (roll < 7)
                    set_timeout(num_t'($urandom_range(1, 6)));
                else if (roll < 9)
                    set_timeout(num_t'($urandom_range(0, 40)));
                else
                    set_timeout('0);
            end
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(20, 60))
            begin
                roll = $urandom_range(0, 99);
                if (roll < 10)
                begin
                    post(random_event());
                end
                else
                begin
                    case (link_phase)
                        PH_IDLE:
                        begin
                            if (roll < 88)
                                post_ctl(sawarq_pkg::OP_OPEN);
                            else
                                post_ctl(op_code_t'($urandom_range(0, 7)));
                        end
                        PH_OPEN_WAIT:
                        begin
                            if (roll < 70)
                                post_rx(sawarq_pkg::RX_SYN_ACK, sawarq_pkg::SEQ_CTRL, 1'b1);
                            else if (roll < 85)
                                post_ctl(sawarq_pkg::OP_TICK);
                            else
                                post(broken_reply(sawarq_pkg::RX_SYN_ACK,
                                                  sawarq_pkg::SEQ_CTRL));
                        end
                        PH_READY:
                        begin
                            if (roll < 85)
                            begin
                                ev = random_event();
                                ev.op = sawarq_pkg::OP_SEND;
                                ev.seg_first = ($urandom_range(0, 3) == 0);
                                ev.seg_last  = ($urandom_range(0, 3) == 0);
                                if ($urandom_range(0, 9) != 0)
                                    ev.seg_size = len_t'($urandom_range(0, 64));
                                post(ev);
                            end
                            else if (roll < 94)
                                post_ctl(sawarq_pkg::OP_CLOSE);
                            else
                                post_ctl($urandom_range(0, 1) ? sawarq_pkg::OP_TICK
                                                              : sawarq_pkg::OP_RECV);
                        end
                        PH_DATA_WAIT:
                        begin
                            if (roll < 60)
                                post_rx(sawarq_pkg::RX_ACK, seq_count, 1'b1);
                            else if (roll < 82)
                                post_ctl(sawarq_pkg::OP_TICK);
                            else
                                post(broken_reply(sawarq_pkg::RX_ACK, seq_count));
                        end
                        PH_FIN_WAIT:
                        begin
                            if (roll < 65)
                                post_rx(sawarq_pkg::RX_ACK, '0, 1'b1);
                            else if (roll < 87)
                                post_ctl(sawarq_pkg::OP_TICK);
                            else
                                post(broken_reply(sawarq_pkg::RX_ACK, '0));
                        end
                        default:
                        begin
                            if (roll < 72)
                                post_rx(sawarq_pkg::RX_FIN_ACK, sawarq_pkg::SEQ_CTRL, 1'b1);
                            else if (roll < 80)
                                post_ctl(sawarq_pkg::OP_TICK);
                            else
                                post(broken_reply(sawarq_pkg::RX_FIN_ACK,
                                                  sawarq_pkg::SEQ_CTRL));
                        end
                    endcase
                end
            end
            // pause the sender until every reply is in
            if ($urandom_range(0, 2) == 0)
            begin
                drain();
            end
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // receiver: long hold-off first, then the per-word gap
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rx_hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                rx_hold_cycles--;
            end
            else if (rx_gap_left > 0)
            begin
                out_stall <= 1'b1;
                rx_gap_left--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : check_replies
        sawarq_pkg::result_t want;
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (expected_replies.size() == 0)
            begin
                $error("result word with no reply expected");
                failures++;
            end
            else
            begin
                want = expected_replies.pop_front();
                if (tx_send !== want.tx_send)
                begin
                    $error("tx_send: expected %0d, actual %0d", want.tx_send, tx_send);
                    failures++;
                end
                if (tx_flag !== want.tx_flag)
                begin
                    $error("tx_flag: expected %0d, actual %0d", want.tx_flag, tx_flag);
                    failures++;
                end
                if (tx_seq !== want.tx_seq)
                begin
                    $error("tx_seq: expected %0d, actual %0d", want.tx_seq, tx_seq);
                    failures++;
                end
                if (tx_stream !== want.tx_stream)
                begin
                    $error("tx_stream: expected %0d, actual %0d", want.tx_stream, tx_stream);
                    failures++;
                end
                if (tx_size !== want.tx_size)
                begin
                    $error("tx_size: expected %0d, actual %0d", want.tx_size, tx_size);
                    failures++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, status);
                    failures++;
                end
            end
            rx_gap_left = rx_idle_on ? $urandom_range(0, 12) : 0;
        end
    end

    initial
    begin
        #4000000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        link_phase    = PH_IDLE;
        seq_count     = '0;
        stream_count  = '0;
        wait_timer    = '0;
        held_flag     = sawarq_pkg::FL_NONE;
        held_size     = '0;
        timeout_ticks = sawarq_pkg::TIMEOUT_RESET;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        test_directed_session();
        test_handshake_failures();
        test_timeout_extremes();
        test_retransmit();
        test_backpressure();
        test_random_sessions();
        drain();

        if (failures == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
